// File: hw/rtl/cst_pkg.sv
// types, constants and character helpers shared by the tokenizer modules
`timescale 1ns / 1ps

package cst_pkg;

    localparam int CHAR_W   = 8;
    localparam int KIND_W   = 5;
    localparam int START_W  = 24;
    localparam int LEN_W    = 8;
    localparam int CLS_W    = 4;
    localparam int KW_NUM   = 4;
    localparam int KW_IDX_W = 3;
    localparam int KW_MAX   = 6;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_EOF     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 5'd1;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd2;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_EQEQ    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_NE      = 5'd5;
    localparam logic [KIND_W-1:0] KIND_LE      = 5'd6;
    localparam logic [KIND_W-1:0] KIND_GE      = 5'd7;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd8;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd10;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd12;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd13;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd14;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd16;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd18;
    localparam logic [KIND_W-1:0] KIND_LT      = 5'd19;
    localparam logic [KIND_W-1:0] KIND_GT      = 5'd20;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd21;

    localparam logic [CLS_W-1:0] CLS_SPACE  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_LETTER = 4'd1;
    localparam logic [CLS_W-1:0] CLS_DIGIT  = 4'd2;
    localparam logic [CLS_W-1:0] CLS_EQ     = 4'd3;
    localparam logic [CLS_W-1:0] CLS_BANG   = 4'd4;
    localparam logic [CLS_W-1:0] CLS_LT     = 4'd5;
    localparam logic [CLS_W-1:0] CLS_GT     = 4'd6;
    localparam logic [CLS_W-1:0] CLS_SINGLE = 4'd7;
    localparam logic [CLS_W-1:0] CLS_OTHER  = 4'd8;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eoi;
        logic [CLS_W-1:0]  cls;
        logic [KIND_W-1:0] op_kind;
    } t_beat;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_token;

    function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            "=":     k = KIND_ASSIGN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ",":     k = KIND_COMMA;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            default: k = KIND_EOF;
        endcase
        return k;
    endfunction

    function automatic logic [CLS_W-1:0] classify(input logic [CHAR_W-1:0] c);
        logic [CLS_W-1:0] cls;
        priority if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
            cls = CLS_SPACE;
        end else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
            cls = CLS_LETTER;
        end else if (c >= "0" && c <= "9") begin
            cls = CLS_DIGIT;
        end else if (c == "=") begin
            cls = CLS_EQ;
        end else if (c == "!") begin
            cls = CLS_BANG;
        end else if (c == "<") begin
            cls = CLS_LT;
        end else if (c == ">") begin
            cls = CLS_GT;
        end else if (single_kind(c) != KIND_EOF) begin
            cls = CLS_SINGLE;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    // keyword order: int, return, if, else
    function automatic logic [KW_IDX_W-1:0] kw_len(input logic [1:0] k);
        logic [KW_IDX_W-1:0] n;
        unique case (k)
            2'd0:    n = 3'd3;
            2'd1:    n = 3'd6;
            2'd2:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] k,
                                                  input logic [KW_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        ch = 8'd0;
        unique case (k)
            2'd0: begin
                unique case (idx)
                    3'd0:    ch = "i";
                    3'd1:    ch = "n";
                    3'd2:    ch = "t";
                    default: ch = 8'd0;
                endcase
            end
            2'd1: begin
                unique case (idx)
                    3'd0:    ch = "r";
                    3'd1:    ch = "e";
                    3'd2:    ch = "t";
                    3'd3:    ch = "u";
                    3'd4:    ch = "r";
                    3'd5:    ch = "n";
                    default: ch = 8'd0;
                endcase
            end
            2'd2: begin
                unique case (idx)
                    3'd0:    ch = "i";
                    3'd1:    ch = "f";
                    default: ch = 8'd0;
                endcase
            end
            default: begin
                unique case (idx)
                    3'd0:    ch = "e";
                    3'd1:    ch = "l";
                    3'd2:    ch = "s";
                    3'd3:    ch = "e";
                    default: ch = 8'd0;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/cst_front.sv
// front end: classifies source beats and queues them for the scanner
`timescale 1ns / 1ps

module cst_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_source_char,
    input  logic               i_end_of_input,
    output logic               o_beat_valid,
    output cst_pkg::t_beat     o_beat,
    input  logic               i_beat_take
);
    import cst_pkg::*;

    t_beat                r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0]  r_wr_ptr;
    logic [FQ_PTR_W-1:0]  r_rd_ptr;
    logic [FQ_CNT_W-1:0]  r_count;
    logic                 push_ok;
    t_beat                in_beat;

    assign full         = (r_count == FQ_CNT_W'(FQ_DEPTH));
    assign push_ok      = push && !full;
    assign o_beat_valid = (r_count != '0);
    assign o_beat       = r_mem[r_rd_ptr];

    always_comb begin
        in_beat.ch      = i_source_char;
        in_beat.eoi     = i_end_of_input;
        in_beat.cls     = classify(i_source_char);
        in_beat.op_kind = single_kind(i_source_char);
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_beat_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FQ_CNT_W'(push_ok) - FQ_CNT_W'(i_beat_take);
        end
    end

    a_take_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_beat_take |-> o_beat_valid)
        else $error("scanner took a beat from an empty queue");

endmodule

// File: hw/rtl/cst_back.sv
// scanner: runs the token state machine and forms up to two tokens per beat
`timescale 1ns / 1ps

module cst_back #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_WIDTH  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat_valid,
    input  cst_pkg::t_beat     i_beat,
    output logic               o_beat_take,
    input  logic               i_room,
    output logic [1:0]         o_wr_cnt,
    output cst_pkg::t_token    o_tok0,
    output cst_pkg::t_token    o_tok1
);
    import cst_pkg::*;

    localparam int RUN_W = $clog2(MAX_TOKEN_LEN + 1);

    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_IDENT  = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_EQ     = 3'd3;
    localparam logic [2:0] MODE_BANG   = 3'd4;
    localparam logic [2:0] MODE_LT     = 3'd5;
    localparam logic [2:0] MODE_GT     = 3'd6;

    logic [2:0]              r_mode,    n_mode;
    logic [OFFSET_WIDTH-1:0] r_start,   n_start;
    logic [RUN_W-1:0]        r_run_len, n_run_len;
    logic [KW_NUM-1:0]       r_kw_alive, n_kw_alive;
    logic [OFFSET_WIDTH-1:0] r_pos,     n_pos;
    logic                    r_halted,  n_halted;

    logic                    take;
    logic                    scan;
    logic                    more;
    logic                    is_kw;
    logic                    idx_ok;
    logic [KW_IDX_W-1:0]     kw_idx;
    logic [KW_NUM-1:0]       kw_first;
    logic [KW_NUM-1:0]       kw_next;
    logic [KW_NUM-1:0]       kw_len_hit;
    logic [KIND_W-1:0]       flush_kind;
    logic [LEN_W-1:0]        flush_len;
    logic [KIND_W-1:0]       pend_single;
    logic [KIND_W-1:0]       pend_double;
    logic                    a_valid, b_valid;
    logic [KIND_W-1:0]       a_kind,  b_kind;
    logic [OFFSET_WIDTH-1:0] a_start, b_start;
    logic [LEN_W-1:0]        a_len,   b_len;

    assign take        = i_beat_valid && i_room;
    assign o_beat_take = take;

    assign idx_ok = (32'(r_run_len) < KW_MAX);
    assign kw_idx = KW_IDX_W'(r_run_len);

    always_comb begin
        for (int k = 0; k < KW_NUM; k++) begin
            kw_first[k]   = (kw_char(2'(k), '0) == i_beat.ch);
            kw_next[k]    = idx_ok && (kw_idx < kw_len(2'(k)))
                            && (kw_char(2'(k), kw_idx) == i_beat.ch);
            kw_len_hit[k] = (RUN_W'(kw_len(2'(k))) == r_run_len);
        end
    end

    assign is_kw      = |(r_kw_alive & kw_len_hit);
    assign flush_kind = (r_mode == MODE_IDENT) ? (is_kw ? KIND_KEYWORD : KIND_IDENT)
                                                : KIND_NUMBER;
    assign flush_len  = (32'(r_run_len) > 32'(LEN_SAT)) ? LEN_SAT : LEN_W'(r_run_len);
    assign more       = (i_beat.cls == CLS_DIGIT)
                        || ((r_mode == MODE_IDENT) && (i_beat.cls == CLS_LETTER));

    always_comb begin
        unique case (r_mode)
            MODE_EQ: begin
                pend_single = KIND_ASSIGN;
                pend_double = KIND_EQEQ;
            end
            MODE_BANG: begin
                pend_single = KIND_ERROR;
                pend_double = KIND_NE;
            end
            MODE_LT: begin
                pend_single = KIND_LT;
                pend_double = KIND_LE;
            end
            default: begin
                pend_single = KIND_GT;
                pend_double = KIND_GE;
            end
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_start    = r_start;
        n_run_len  = r_run_len;
        n_kw_alive = r_kw_alive;
        n_pos      = r_pos;
        n_halted   = r_halted;
        a_valid    = 1'b0;
        a_kind     = KIND_EOF;
        a_start    = r_start;
        a_len      = '0;
        b_valid    = 1'b0;
        b_kind     = KIND_EOF;
        b_start    = r_pos;
        b_len      = '0;
        scan       = 1'b0;
        if (!r_halted) begin
            if (i_beat.eoi) begin
                unique case (r_mode)
                    MODE_IDENT, MODE_NUMBER: begin
                        a_valid = 1'b1;
                        a_kind  = flush_kind;
                        a_len   = flush_len;
                    end
                    MODE_BANG: begin
                        a_valid  = 1'b1;
                        a_kind   = KIND_ERROR;
                        a_len    = LEN_W'(1);
                        n_halted = 1'b1;
                    end
                    MODE_EQ, MODE_LT, MODE_GT: begin
                        a_valid = 1'b1;
                        a_kind  = pend_single;
                        a_len   = LEN_W'(1);
                    end
                    default: ;
                endcase
                n_mode = MODE_IDLE;
                if (r_mode != MODE_BANG) begin
                    b_valid = 1'b1;
                    b_kind  = KIND_EOF;
                end
            end else begin
                n_pos = r_pos + 1'b1;
                scan  = 1'b1;
                unique case (r_mode)
                    MODE_IDENT, MODE_NUMBER: begin
                        if (more) begin
                            scan = 1'b0;
                            if (r_mode == MODE_IDENT) begin
                                n_kw_alive = r_kw_alive & kw_next;
                            end
                            if (32'(r_run_len) < MAX_TOKEN_LEN) begin
                                n_run_len = r_run_len + 1'b1;
                            end
                        end else begin
                            a_valid = 1'b1;
                            a_kind  = flush_kind;
                            a_len   = flush_len;
                            n_mode  = MODE_IDLE;
                        end
                    end
                    MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
                        n_mode  = MODE_IDLE;
                        a_valid = 1'b1;
                        if (i_beat.cls == CLS_EQ) begin
                            scan   = 1'b0;
                            a_kind = pend_double;
                            a_len  = LEN_W'(2);
                        end else if (r_mode == MODE_BANG) begin
                            scan     = 1'b0;
                            a_kind   = KIND_ERROR;
                            a_len    = LEN_W'(1);
                            n_halted = 1'b1;
                        end else begin
                            a_kind = pend_single;
                            a_len  = LEN_W'(1);
                        end
                    end
                    default: ;
                endcase
                if (scan) begin
                    unique case (i_beat.cls)
                        CLS_SPACE: ;
                        CLS_LETTER: begin
                            n_mode     = MODE_IDENT;
                            n_start    = r_pos;
                            n_run_len  = RUN_W'(1);
                            n_kw_alive = kw_first;
                        end
                        CLS_DIGIT: begin
                            n_mode     = MODE_NUMBER;
                            n_start    = r_pos;
                            n_run_len  = RUN_W'(1);
                            n_kw_alive = '1;
                        end
                        CLS_EQ, CLS_BANG, CLS_LT, CLS_GT: begin
                            n_mode    = (i_beat.cls == CLS_EQ)   ? MODE_EQ   :
                                        (i_beat.cls == CLS_BANG) ? MODE_BANG :
                                        (i_beat.cls == CLS_LT)   ? MODE_LT   : MODE_GT;
                            n_start   = r_pos;
                            n_run_len = RUN_W'(1);
                        end
                        CLS_SINGLE: begin
                            b_valid = 1'b1;
                            b_kind  = i_beat.op_kind;
                            b_len   = LEN_W'(1);
                        end
                        default: begin
                            b_valid  = 1'b1;
                            b_kind   = KIND_ERROR;
                            b_len    = LEN_W'(1);
                            n_halted = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    // pack: the flushed run's token goes first, the last token carries the run mark
    always_comb begin
        o_tok1.kind   = b_kind;
        o_tok1.start  = START_W'(b_start);
        o_tok1.length = b_len;
        o_tok1.last   = 1'b1;
        if (a_valid) begin
            o_tok0.kind   = a_kind;
            o_tok0.start  = START_W'(a_start);
            o_tok0.length = a_len;
            o_tok0.last   = !b_valid;
        end else begin
            o_tok0 = o_tok1;
        end
        o_wr_cnt = take ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_start    <= '0;
            r_run_len  <= '0;
            r_kw_alive <= '1;
            r_pos      <= '0;
            r_halted   <= 1'b0;
        end else if (take) begin
            r_mode     <= n_mode;
            r_start    <= n_start;
            r_run_len  <= n_run_len;
            r_kw_alive <= n_kw_alive;
            r_pos      <= n_pos;
            r_halted   <= n_halted;
        end
    end

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (o_wr_cnt == 2'd0))
        else $error("token written after halt");

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_beat.eoi && !r_halted) |=> (r_mode == MODE_IDLE))
        else $error("end mark left a token pending");

    a_pair_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_cnt == 2'd2) |-> (!o_tok0.last && o_tok1.last))
        else $error("bad run mark on a token pair");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_wr_cnt != 2'd0) && (o_tok0.kind != KIND_EOF)) |-> (o_tok0.length != '0))
        else $error("zero length on a non eof token");

endmodule

// File: hw/rtl/cst_outq.sv
// result queue: takes up to two tokens per cycle, hands out one per pop
`timescale 1ns / 1ps

module cst_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_wr_cnt,
    input  cst_pkg::t_token    i_tok0,
    input  cst_pkg::t_token    i_tok1,
    output logic               o_room,
    output logic               empty,
    input  logic               pop,
    output cst_pkg::t_token    o_head
);
    import cst_pkg::*;

    t_token               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wr_ptr;
    logic [OQ_PTR_W-1:0]  r_rd_ptr;
    logic [OQ_CNT_W-1:0]  r_count;
    logic                 pop_ok;

    assign empty  = (r_count == '0);
    assign pop_ok = pop && !empty;
    assign o_room = (r_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign o_head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_tok0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(i_wr_cnt);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OQ_CNT_W'(i_wr_cnt) - OQ_CNT_W'(pop_ok);
        end
    end

    a_write_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_cnt != 2'd0) |-> o_room)
        else $error("tokens written without room");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

endmodule

// File: hw/rtl/c_subset_tokenizer.sv
// top level of the streaming tokenizer for a small c subset
`timescale 1ns / 1ps

// Streaming lexer: push one source byte per beat (or an end mark); pop tokens
// with kind, start offset and length, last_of_run marking the final token a
// beat caused. A beat can be pushed every cycle while full is low: a
// four-entry classified beat queue feeds the scanner, which retires one
// beat per cycle while the four-entry token queue has room for two tokens.
// A beat is registered in the beat queue and its tokens in the token queue
// before they reach the result ports; beats yielding two tokens take two
// pops, so sustained rate is set by the result side. After an error token
// the block drops all input until reset. No clearing pass after reset.
module c_subset_tokenizer #(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int OFFSET_WIDTH  = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_source_char,
    input  logic        i_end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token_kind,
    output logic [23:0] o_token_start,
    output logic [7:0]  o_token_length,
    output logic        o_last_of_run
);
    import cst_pkg::*;

    logic       beat_valid;
    t_beat      beat;
    logic       beat_take;
    logic       room;
    logic [1:0] wr_cnt;
    t_token     tok0;
    t_token     tok1;
    t_token     head;

    cst_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_source_char  (i_source_char),
        .i_end_of_input (i_end_of_input),
        .o_beat_valid   (beat_valid),
        .o_beat         (beat),
        .i_beat_take    (beat_take)
    );

    cst_back #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .OFFSET_WIDTH  (OFFSET_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_beat_take  (beat_take),
        .i_room       (room),
        .o_wr_cnt     (wr_cnt),
        .o_tok0       (tok0),
        .o_tok1       (tok1)
    );

    cst_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (wr_cnt),
        .i_tok0   (tok0),
        .i_tok1   (tok1),
        .o_room   (room),
        .empty    (empty),
        .pop      (pop),
        .o_head   (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule
